@@ sv/apvg_pkg.sv @@
// Package of types, constants and tables for the arc polyline vertex generator.
package apvg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int TABLE_BITS     = 24;
  localparam int WIDTH_BITS     = 8;
  localparam int STEP_DEG       = 10;
  localparam int FULL_TURN      = 360;
  localparam int HALF_TURN      = 180;
  localparam int QUARTER_TURN   = 90;
  localparam int CNT_BITS       = 6;
  localparam int ITER_BITS      = 5;
  localparam int MAX_STEPS      = 36;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ATAN_START,
    ST_ATAN_END,
    ST_SWEEP,
    ST_EMIT_START,
    ST_ROTATE,
    ST_EMIT_ROT,
    ST_EMIT_END
  } apvg_state_e;

  typedef enum logic [1:0] {
    VSEL_START,
    VSEL_ROT,
    VSEL_END
  } apvg_vsel_e;

  typedef struct packed {
    logic       load;
    logic       atan_go;
    logic       atan_sel_end;
    logic       sweep_calc;
    logic       rot_go;
    logic       emit;
    apvg_vsel_e vsel;
  } apvg_cmd_t;

  typedef struct packed {
    logic                zero_width;
    logic                atan_done;
    logic                sweep_done;
    logic                rot_done;
    logic [CNT_BITS-1:0] steps;
  } apvg_stat_t;

  function automatic logic signed [31:0] atan_q24(input logic [ITER_BITS-1:0] i);
    logic signed [31:0] r;
    r = 32'sd0;
    case (i)
      5'd0:  r = 32'sd754974720;
      5'd1:  r = 32'sd445687602;
      5'd2:  r = 32'sd235489088;
      5'd3:  r = 32'sd119537938;
      5'd4:  r = 32'sd60000934;
      5'd5:  r = 32'sd30029717;
      5'd6:  r = 32'sd15018523;
      5'd7:  r = 32'sd7509720;
      5'd8:  r = 32'sd3754917;
      5'd9:  r = 32'sd1877466;
      5'd10: r = 32'sd938734;
      5'd11: r = 32'sd469367;
      5'd12: r = 32'sd234684;
      5'd13: r = 32'sd117342;
      5'd14: r = 32'sd58671;
      5'd15: r = 32'sd29335;
      5'd16: r = 32'sd14668;
      5'd17: r = 32'sd7334;
      5'd18: r = 32'sd3667;
      5'd19: r = 32'sd1833;
      5'd20: r = 32'sd917;
      5'd21: r = 32'sd458;
      5'd22: r = 32'sd229;
      5'd23: r = 32'sd115;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sin_q24(input logic [3:0] k);
    logic signed [31:0] r;
    r = 32'sd0;
    case (k)
      4'd0: r = 32'sd0;
      4'd1: r = 32'sd2913333;
      4'd2: r = 32'sd5738146;
      4'd3: r = 32'sd8388608;
      4'd4: r = 32'sd10784187;
      4'd5: r = 32'sd12852093;
      4'd6: r = 32'sd14529495;
      4'd7: r = 32'sd15765426;
      4'd8: r = 32'sd16522332;
      4'd9: r = 32'sd16777216;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/apvg_ctrl.sv @@
// Controller state machine of the arc polyline vertex generator.
module apvg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  apvg_pkg::apvg_stat_t stat_i,
  output apvg_pkg::apvg_cmd_t  cmd_o
);
  import apvg_pkg::*;

  apvg_state_e         state_q, state_d;
  logic [CNT_BITS-1:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.vsel = VSEL_START;
    busy    = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = ST_ATAN_START;
        end
      end
      ST_ATAN_START: begin
        if (stat_i.zero_width) begin
          state_d = ST_IDLE;
        end else if (stat_i.atan_done) begin
          cmd_o.atan_go = 1'b1;
          cmd_o.atan_sel_end = 1'b1;
          state_d = ST_ATAN_END;
        end
      end
      ST_ATAN_END: begin
        if (stat_i.atan_done) begin
          cmd_o.sweep_calc = 1'b1;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (stat_i.sweep_done) begin
          state_d = ST_EMIT_START;
        end
      end
      ST_EMIT_START: begin
        cmd_o.emit = 1'b1;
        cmd_o.vsel = VSEL_START;
        k_d = CNT_BITS'(1);
        if (stat_i.steps == '0) begin
          state_d = ST_EMIT_END;
        end else begin
          cmd_o.rot_go = 1'b1;
          state_d = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        if (stat_i.rot_done) begin
          state_d = ST_EMIT_ROT;
        end
      end
      ST_EMIT_ROT: begin
        cmd_o.emit = 1'b1;
        cmd_o.vsel = VSEL_ROT;
        if (k_q == stat_i.steps) begin
          state_d = ST_EMIT_END;
        end else begin
          k_d = k_q + CNT_BITS'(1);
          cmd_o.rot_go = 1'b1;
          state_d = ST_ROTATE;
        end
      end
      ST_EMIT_END: begin
        cmd_o.emit = 1'b1;
        cmd_o.vsel = VSEL_END;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> busy) else $error("emit while idle");
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_END) |=> (state_q == ST_IDLE)) else $error("end not final");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_ROT) |-> (k_q <= stat_i.steps)) else $error("step overrun");

endmodule

@@ sv/apvg_dp.sv @@
// Datapath of the arc polyline vertex generator: CORDIC atan2, sweep and rotation.
module apvg_dp #(
  parameter int COORD_BITS = apvg_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = apvg_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  apvg_pkg::apvg_cmd_t               cmd_i,
  output apvg_pkg::apvg_stat_t              stat_o,
  input  logic signed [COORD_BITS-1:0]      center_x_i,
  input  logic signed [COORD_BITS-1:0]      center_y_i,
  input  logic signed [COORD_BITS-1:0]      start_x_i,
  input  logic signed [COORD_BITS-1:0]      start_y_i,
  input  logic signed [COORD_BITS-1:0]      end_x_i,
  input  logic signed [COORD_BITS-1:0]      end_y_i,
  input  logic [apvg_pkg::WIDTH_BITS-1:0]   line_width_i,
  output logic signed [COORD_BITS-1:0]      vertex_x_o,
  output logic signed [COORD_BITS-1:0]      vertex_y_o,
  output logic [apvg_pkg::WIDTH_BITS-1:0]   stroke_width_o,
  output logic                              last_o,
  output logic                              valid_o
);
  import apvg_pkg::*;

  localparam int OFS_BITS = COORD_BITS + 1;
  // CORDIC vector grows by under 1.65x plus one bit for the quadrant turn.
  localparam int CX_BITS  = OFS_BITS + FRAC_BITS + 3;
  localparam int ANG_BITS = FRAC_BITS + 11;
  localparam int TRIG_BITS = FRAC_BITS + 2;
  localparam int PROD_BITS = TRIG_BITS + OFS_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int TSHIFT    = TABLE_BITS - FRAC_BITS;
  localparam int IT_MAX    = (FRAC_BITS < TABLE_BITS) ? FRAC_BITS : TABLE_BITS;
  localparam logic signed [ANG_BITS-1:0] DEG_90   = ANG_BITS'(QUARTER_TURN) <<< FRAC_BITS;
  localparam logic signed [ANG_BITS-1:0] DEG_180  = ANG_BITS'(HALF_TURN) <<< FRAC_BITS;
  localparam logic signed [ANG_BITS-1:0] DEG_360  = ANG_BITS'(FULL_TURN) <<< FRAC_BITS;
  localparam logic signed [ANG_BITS-1:0] DEG_STEP = ANG_BITS'(STEP_DEG) <<< FRAC_BITS;
  localparam logic signed [SUM_BITS-1:0] COORD_HI = SUM_BITS'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] COORD_LO = -SUM_BITS'(1 << (COORD_BITS - 1));

  logic signed [COORD_BITS-1:0] cx_q, cy_q, sx_q, sy_q, ex_q, ey_q;
  logic [WIDTH_BITS-1:0]        w_q;
  logic signed [OFS_BITS-1:0]   dx_q, dy_q, fx_q, fy_q;
  logic signed [CX_BITS-1:0]    vx_q, vy_q;
  logic signed [ANG_BITS-1:0]   z_q, a0_q, sweep_q;
  logic [ITER_BITS-1:0]         it_q;
  logic                         cbusy_q;
  logic [CNT_BITS-1:0]          n_q, n_cnt_q, k_q;
  logic signed [ANG_BITS-1:0]   div_rem_q;
  logic [1:0]                   rph_q;
  logic signed [PROD_BITS-1:0]  pcx_q, psy_q, psx_q, pcy_q;
  logic signed [COORD_BITS-1:0] rx_q, ry_q;
  logic signed [COORD_BITS-1:0] ox_q, oy_q;
  logic                         olast_q, ovalid_q;

  // Load and offsets.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q <= center_x_i; cy_q <= center_y_i;
      sx_q <= start_x_i;  sy_q <= start_y_i;
      ex_q <= end_x_i;    ey_q <= end_y_i;
      w_q  <= line_width_i;
      dx_q <= OFS_BITS'(start_x_i) - OFS_BITS'(center_x_i);
      dy_q <= OFS_BITS'(start_y_i) - OFS_BITS'(center_y_i);
      fx_q <= OFS_BITS'(end_x_i) - OFS_BITS'(center_x_i);
      fy_q <= OFS_BITS'(end_y_i) - OFS_BITS'(center_y_i);
    end
  end

  // CORDIC vectoring, one iteration per cycle.
  logic signed [OFS_BITS-1:0] ax, ay;
  logic signed [CX_BITS-1:0]  xs, ys;
  logic signed [31:0]         tab;
  logic signed [ANG_BITS-1:0] stepa;
  always_comb begin
    if (cmd_i.load) begin
      ax = OFS_BITS'(start_x_i) - OFS_BITS'(center_x_i);
      ay = OFS_BITS'(start_y_i) - OFS_BITS'(center_y_i);
    end else if (cmd_i.atan_sel_end) begin
      ax = fx_q;
      ay = fy_q;
    end else begin
      ax = dx_q;
      ay = dy_q;
    end
    xs = vx_q >>> it_q;
    ys = vy_q >>> it_q;
    tab = atan_q24(it_q);
    if (TSHIFT == 0) stepa = ANG_BITS'(tab);
    else stepa = ANG_BITS'((tab + (32'sd1 <<< (TSHIFT - 1))) >>> TSHIFT);
  end

  logic start_go;
  assign start_go = cmd_i.load || cmd_i.atan_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cbusy_q <= 1'b0;
      it_q    <= '0;
    end else if (start_go) begin
      it_q <= '0;
      cbusy_q <= !(ay == '0 || ax == '0);
    end else if (cbusy_q) begin
      it_q <= it_q + ITER_BITS'(1);
      if (32'(it_q) == IT_MAX - 1) cbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_go) begin
      if (ay == '0) begin
        z_q <= (ax >= 0) ? '0 : DEG_180;
      end else if (ax == '0) begin
        z_q <= (ay > 0) ? DEG_90 : -DEG_90;
      end else if (ax < 0) begin
        if (ay > 0) begin
          vx_q <= CX_BITS'(ay) <<< FRAC_BITS;
          vy_q <= CX_BITS'(-ax) <<< FRAC_BITS;
          z_q  <= DEG_90;
        end else begin
          vx_q <= CX_BITS'(-ay) <<< FRAC_BITS;
          vy_q <= CX_BITS'(ax) <<< FRAC_BITS;
          z_q  <= -DEG_90;
        end
      end else begin
        vx_q <= CX_BITS'(ax) <<< FRAC_BITS;
        vy_q <= CX_BITS'(ay) <<< FRAC_BITS;
        z_q  <= '0;
      end
    end else if (cbusy_q) begin
      if (vy_q >= 0) begin
        vx_q <= vx_q + ys; vy_q <= vy_q - xs; z_q <= z_q + stepa;
      end else begin
        vx_q <= vx_q - ys; vy_q <= vy_q + xs; z_q <= z_q - stepa;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.atan_go) a0_q <= z_q;
  end

  // Sweep and step count by repeated subtraction.
  logic signed [ANG_BITS-1:0] sw;
  always_comb begin
    sw = a0_q - z_q;
    if (sw < 0) sw = sw + DEG_360;
    if (sw <= 0) sw = DEG_360;
    if (sw > DEG_360) sw = DEG_360;
  end

  logic dbusy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      n_cnt_q <= '0;
    end else if (cmd_i.sweep_calc) begin
      dbusy_q <= 1'b1;
      n_cnt_q <= '0;
    end else if (dbusy_q) begin
      if (div_rem_q >= DEG_STEP) n_cnt_q <= n_cnt_q + CNT_BITS'(1);
      else dbusy_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_calc) div_rem_q <= sw;
    else if (dbusy_q && div_rem_q >= DEG_STEP) div_rem_q <= div_rem_q - DEG_STEP;
  end
  assign sweep_q = div_rem_q;
  assign n_q = n_cnt_q;

  // Rotation: table lookup and products, then sums.
  logic [CNT_BITS-1:0] kc;
  logic signed [TRIG_BITS-1:0] s_v, c_v;
  function automatic logic signed [TRIG_BITS-1:0] trig(input logic [CNT_BITS-1:0] kk);
    logic [CNT_BITS-1:0] m;
    logic signed [31:0]  t;
    logic signed [31:0]  r;
    m = (kk >= CNT_BITS'(MAX_STEPS)) ? kk - CNT_BITS'(MAX_STEPS) : kk;
    if (m <= 9)       t = sin_q24(4'(m));
    else if (m <= 18) t = sin_q24(4'(CNT_BITS'(18) - m));
    else if (m <= 27) t = sin_q24(4'(m - CNT_BITS'(18)));
    else              t = sin_q24(4'(CNT_BITS'(MAX_STEPS) - m));
    if (TSHIFT == 0) r = t;
    else r = (t + (32'sd1 <<< (TSHIFT - 1))) >>> TSHIFT;
    if (m > 18) r = -r;
    return TRIG_BITS'(r);
  endfunction

  always_comb begin
    kc  = k_q + CNT_BITS'(9);
    s_v = trig(k_q);
    c_v = trig(kc);
  end

  logic signed [SUM_BITS-1:0] tx, ty, cxs, cys, qx, qy;
  always_comb begin
    cxs = SUM_BITS'(cx_q) <<< FRAC_BITS;
    cys = SUM_BITS'(cy_q) <<< FRAC_BITS;
    tx = cxs + SUM_BITS'(pcx_q) + SUM_BITS'(psy_q);
    ty = cys - SUM_BITS'(psx_q) + SUM_BITS'(pcy_q);
    qx = (tx < 0) ? -((-tx) >>> FRAC_BITS) : (tx >>> FRAC_BITS);
    qy = (ty < 0) ? -((-ty) >>> FRAC_BITS) : (ty >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rph_q <= '0;
      k_q   <= '0;
    end else begin
      if (cmd_i.emit && cmd_i.vsel == VSEL_START) k_q <= CNT_BITS'(1);
      else if (cmd_i.emit && cmd_i.vsel == VSEL_ROT) k_q <= k_q + CNT_BITS'(1);
      if (cmd_i.rot_go) rph_q <= 2'd1;
      else if (rph_q == 2'd1) rph_q <= 2'd2;
      else if (rph_q == 2'd2) rph_q <= 2'd3;
      else if (rph_q == 2'd3) rph_q <= 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rph_q == 2'd1) begin
      pcx_q <= PROD_BITS'(c_v) * PROD_BITS'(dx_q);
      psy_q <= PROD_BITS'(s_v) * PROD_BITS'(dy_q);
      psx_q <= PROD_BITS'(s_v) * PROD_BITS'(dx_q);
      pcy_q <= PROD_BITS'(c_v) * PROD_BITS'(dy_q);
    end
    if (rph_q == 2'd2) begin
      rx_q <= (qx > COORD_HI) ? COORD_BITS'(COORD_HI) :
              (qx < COORD_LO) ? COORD_BITS'(COORD_LO) : COORD_BITS'(qx);
      ry_q <= (qy > COORD_HI) ? COORD_BITS'(COORD_HI) :
              (qy < COORD_LO) ? COORD_BITS'(COORD_LO) : COORD_BITS'(qy);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      ovalid_q <= cmd_i.emit;
      olast_q  <= cmd_i.emit && (cmd_i.vsel == VSEL_END);
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.vsel)
        VSEL_START: begin ox_q <= sx_q; oy_q <= sy_q; end
        VSEL_ROT:   begin ox_q <= rx_q; oy_q <= ry_q; end
        VSEL_END:   begin ox_q <= ex_q; oy_q <= ey_q; end
        default:    begin ox_q <= ex_q; oy_q <= ey_q; end
      endcase
    end
  end

  assign vertex_x_o     = ox_q;
  assign vertex_y_o     = oy_q;
  assign stroke_width_o = w_q;
  assign last_o         = olast_q;
  assign valid_o        = ovalid_q;

  assign stat_o.zero_width = (w_q == '0);
  assign stat_o.atan_done  = !cbusy_q;
  assign stat_o.sweep_done = !dbusy_q;
  assign stat_o.rot_done   = (rph_q == 2'd3);
  assign stat_o.steps      = (dbusy_q || cmd_i.sweep_calc) ? '0 : n_q;

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o) else $error("last without strobe");
  a_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dbusy_q |-> (n_q <= CNT_BITS'(MAX_STEPS))) else $error("step count too large");
  a_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbusy_q |-> (sweep_q >= 0 && sweep_q <= DEG_360)) else $error("sweep out of range");

endmodule

@@ sv/arc_polyline_vertex_gen.sv @@
// Top level of the arc polyline vertex generator.
// One request is taken when start is high and busy is low; busy then stays high
// until the last vertex is on the outputs. Two CORDIC atan2 runs find the start and
// end angles (a vector on an axis needs no iterations), the step count is found by
// repeated subtraction and each rotated vertex is formed by table lookup, products
// and sums. There are 0 to 36 rotated vertices between the start and end points.
// A zero line width keeps busy high for one cycle only. Each vertex is shown for
// one cycle with valid_o high from the output register, and the receiver cannot
// stall it; last_o marks the end point.
module arc_polyline_vertex_gen #(
  parameter int COORD_BITS = apvg_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = apvg_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [COORD_BITS-1:0]    center_x_i,
  input  logic signed [COORD_BITS-1:0]    center_y_i,
  input  logic signed [COORD_BITS-1:0]    start_x_i,
  input  logic signed [COORD_BITS-1:0]    start_y_i,
  input  logic signed [COORD_BITS-1:0]    end_x_i,
  input  logic signed [COORD_BITS-1:0]    end_y_i,
  input  logic [apvg_pkg::WIDTH_BITS-1:0] line_width_i,
  output logic                            valid_o,
  output logic signed [COORD_BITS-1:0]    vertex_x_o,
  output logic signed [COORD_BITS-1:0]    vertex_y_o,
  output logic [apvg_pkg::WIDTH_BITS-1:0] stroke_width_o,
  output logic                            last_o
);
  import apvg_pkg::*;

  apvg_cmd_t  cmd;
  apvg_stat_t stat;

  apvg_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .stat_i(stat), .cmd_o(cmd)
  );

  apvg_dp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .center_x_i, .center_y_i, .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .line_width_i, .vertex_x_o, .vertex_y_o, .stroke_width_o, .last_o, .valid_o
  );
endmodule
